### hw/rtl/rpsc_pkg.sv
`timescale 1ns / 1ps

package rpsc_pkg;

    // Key length and derived widths
    localparam int KEY_DIGITS = 4;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 4;
    localparam int KEY_W      = 14;
    localparam int COUNT_W    = 16;
    localparam int POS_W      = (KEY_DIGITS > 1) ? $clog2(KEY_DIGITS) : 1;
    localparam int PCNT_W     = $clog2(KEY_DIGITS + 2);
    localparam int STEP_W     = $clog2(KEY_DIGITS + 1);

    // Run counter values
    localparam logic [PCNT_W-1:0] PCNT_FULL = PCNT_W'(KEY_DIGITS);
    localparam logic [PCNT_W-1:0] PCNT_OVER = PCNT_W'(KEY_DIGITS + 1);
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(KEY_DIGITS - 1);
    localparam logic [STEP_W-1:0] STEPS_ALL = STEP_W'(KEY_DIGITS);

    // Decoupling queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Divide by ten: floor(v * 6554 / 2^16) is exact for v below 2^14
    localparam int DIV10_MUL   = 6554;
    localparam int DIV10_SHIFT = 16;
    localparam int DIV10_PW    = KEY_W + 14;

    // Characters
    localparam logic [CHAR_W-1:0] CH_TAB  = 7'd9;
    localparam logic [CHAR_W-1:0] CH_LF   = 7'd10;
    localparam logic [CHAR_W-1:0] CH_CR   = 7'd13;
    localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CH_ONE  = 7'h31;
    localparam logic [CHAR_W-1:0] CH_NINE = 7'h39;
    localparam logic [CHAR_W-1:0] CH_T_LO = 7'h74;
    localparam logic [CHAR_W-1:0] CH_T_UP = 7'h54;
    localparam logic [CHAR_W-1:0] CH_H_LO = 7'h68;
    localparam logic [CHAR_W-1:0] CH_H_UP = 7'h48;
    localparam logic [CHAR_W-1:0] CH_E_LO = 7'h65;
    localparam logic [CHAR_W-1:0] CH_E_UP = 7'h45;
    localparam logic [7:0]        CH_LO8  = 8'd32;
    localparam logic [7:0]        CH_HI8  = 8'd126;
    localparam logic [7:0]        WRAP8   = 8'd95;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION = 1'b0,
        CFG_START_KEY = 1'b1
    } t_cfg_idx;

    typedef logic [KEY_DIGITS-1:0][DIGIT_W-1:0] t_digits;

    // Classified request passed from front to back
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              start;
        logic              is_space;
        logic              is_nz_digit;
        logic              is_zero;
    } t_item;

    // Configuration seen by the datapath
    typedef struct packed {
        logic    direction;
        logic    busy;
        t_digits start_digits;
    } t_cfg;

    function automatic logic f_is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic f_is_nz_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ONE) && (c <= CH_NINE);
    endfunction

endpackage

### hw/rtl/rpsc_if.sv
`timescale 1ns / 1ps

// Character request channel
interface rpsc_in_if import rpsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              start_of_text;

    modport source (output valid, output in_char, output start_of_text, input ready);
    modport sink   (input valid, input in_char, input start_of_text, output ready);
endinterface

// Result channel
interface rpsc_out_if import rpsc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  out_char;
    logic [COUNT_W-1:0] match_count;

    modport source (output valid, output out_char, output match_count, input ready);
    modport sink   (input valid, input out_char, input match_count, output ready);
endinterface

// Configuration write channel
interface rpsc_cfg_if import rpsc_pkg::*; ();
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [KEY_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/rpsc_keyconv.sv
`timescale 1ns / 1ps

module rpsc_keyconv import rpsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rpsc_cfg_if.sink         i_cfg,
    output t_cfg             o_cfg
);

    logic                  r_direction;
    logic [KEY_W-1:0]      r_val;
    logic [STEP_W-1:0]     r_steps;
    t_digits               r_digits;

    logic [DIV10_PW-1:0]   prod;
    logic [KEY_W-1:0]      quot;
    logic [KEY_W-1:0]      rem;

    assign i_cfg.ready = 1'b1;

    // One decimal digit per cycle while no configuration write arrives, lowest digit first
    always_comb begin
        prod = DIV10_PW'(r_val) * DIV10_PW'(DIV10_MUL);
        quot = prod[DIV10_SHIFT +: KEY_W];
        rem  = r_val - (quot << 3) - (quot << 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_steps     <= '0;
            r_digits    <= '0;
            r_val       <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DIRECTION: r_direction <= i_cfg.data[0];
                CFG_START_KEY: begin
                    r_val   <= i_cfg.data;
                    r_steps <= STEPS_ALL;
                end
                default: r_direction <= r_direction;
            endcase
        end else if (r_steps != '0) begin
            // first remainder ends up in the last digit
            for (int j = KEY_DIGITS - 1; j > 0; j--) begin
                r_digits[j] <= r_digits[j-1];
            end
            r_digits[0] <= rem[DIGIT_W-1:0];
            r_val       <= quot;
            r_steps     <= r_steps - 1'b1;
        end
    end

    assign o_cfg.direction    = r_direction;
    assign o_cfg.busy         = (r_steps != '0);
    assign o_cfg.start_digits = r_digits;

endmodule

### hw/rtl/rpsc_front.sv
`timescale 1ns / 1ps

module rpsc_front import rpsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rpsc_in_if.sink i_in,
    input  logic    i_busy,
    input  logic    i_full,
    output logic    o_push,
    output t_item   o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_push     = r_valid && !i_full;
    assign i_in.ready = !i_busy && (!r_valid || o_push);
    assign accept     = i_in.valid && i_in.ready;

    // Input stage: register and classify the character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.ch          <= i_in.in_char;
            r_item.start       <= i_in.start_of_text;
            r_item.is_space    <= f_is_space(i_in.in_char);
            r_item.is_nz_digit <= f_is_nz_digit(i_in.in_char);
            r_item.is_zero     <= (i_in.in_char == CH_ZERO);
        end
    end

    assign o_item = r_item;

endmodule

### hw/rtl/rpsc_queue.sv
`timescale 1ns / 1ps

module rpsc_queue import rpsc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_item o_item
);

    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;

    function automatic logic [Q_PTR_W-1:0] f_next(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### hw/rtl/rpsc_back.sv
`timescale 1ns / 1ps

module rpsc_back import rpsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    input  t_cfg       i_cfg,
    output logic       o_q_pop,
    rpsc_out_if.source o_out
);

    t_digits            r_key;
    logic [POS_W-1:0]   r_pos;
    t_digits            r_pend;
    logic [PCNT_W-1:0]  r_pcnt;
    logic [CHAR_W-1:0]  r_prev0;
    logic [CHAR_W-1:0]  r_prev1;
    logic [COUNT_W-1:0] r_cnt;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic [COUNT_W-1:0] r_out_count;

    t_digits            n_key;
    logic [POS_W-1:0]   n_pos;
    t_digits            n_pend;
    logic [PCNT_W-1:0]  n_pcnt;
    logic [CHAR_W-1:0]  n_prev0;
    logic [CHAR_W-1:0]  n_prev1;
    logic [COUNT_W-1:0] n_cnt;

    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  shifted;
    logic [POS_W-1:0]   pos_adv;
    logic [CHAR_W-1:0]  out_ch;
    logic               run_digit;
    logic               run_open;
    logic               hit;

    // Shift within the printable range
    function automatic logic [CHAR_W-1:0] f_shift(input logic [CHAR_W-1:0] c,
                                                  input logic [DIGIT_W-1:0] d,
                                                  input logic dec);
        logic [7:0] c8;
        logic [7:0] d8;
        logic [7:0] r8;
        c8 = {1'b0, c};
        d8 = {4'b0, d};
        if (!dec) begin
            if (c8 + d8 > CH_HI8) begin
                r8 = ((c8 >= WRAP8) ? c8 - WRAP8 : c8) + d8;
            end else begin
                r8 = c8 + d8;
            end
        end else begin
            if (c8 < CH_LO8 + d8) begin
                r8 = c8 + WRAP8 - d8;
            end else begin
                r8 = c8 - d8;
            end
        end
        return r8[CHAR_W-1:0];
    endfunction

    function automatic t_digits f_push(input t_digits p, input logic [DIGIT_W-1:0] d);
        t_digits t;
        for (int j = 0; j < KEY_DIGITS - 1; j++) begin
            t[j] = p[j+1];
        end
        t[KEY_DIGITS-1] = d;
        return t;
    endfunction

    assign o_q_pop = i_q_valid && (!r_out_valid || o_out.ready);

    // Per-character state update
    always_comb begin
        n_key   = r_key;
        n_pos   = r_pos;
        n_pend  = r_pend;
        n_pcnt  = r_pcnt;
        n_prev0 = r_prev0;
        n_prev1 = r_prev1;
        n_cnt   = r_cnt;

        if (i_q_item.start) begin
            n_key   = i_cfg.start_digits;
            n_pos   = '0;
            n_pend  = '0;
            n_pcnt  = '0;
            n_prev0 = CH_ZERO;
            n_prev1 = CH_ZERO;
            n_cnt   = '0;
        end

        shifted  = f_shift(i_q_item.ch, n_key[n_pos], i_cfg.direction);
        pos_adv  = (n_pos == POS_LAST) ? '0 : n_pos + 1'b1;
        run_open = (n_pcnt != '0) && (n_pcnt <= PCNT_FULL);
        out_ch   = i_q_item.is_space ? i_q_item.ch : shifted;
        if (!i_q_item.is_space) begin
            n_pos = pos_adv;
        end

        // Digit runs come from the plaintext side
        if (!i_cfg.direction) begin
            run_digit = i_q_item.is_nz_digit || (i_q_item.is_zero && n_pcnt != '0);
            digit     = i_q_item.ch[DIGIT_W-1:0];
        end else begin
            run_digit = f_is_nz_digit(out_ch) || ((out_ch == CH_ZERO) && n_pcnt != '0);
            digit     = out_ch[DIGIT_W-1:0];
        end

        if (run_digit) begin
            if (n_pcnt < PCNT_FULL) begin
                n_pend = f_push(n_pend, digit);
                n_pcnt = n_pcnt + 1'b1;
            end else begin
                n_pcnt = PCNT_OVER;
            end
        end else if (run_open) begin
            n_key  = n_pend;
            n_pend = '0;
            n_pcnt = '0;
            n_pos  = '0;
        end else if (n_pcnt != '0) begin
            n_pend = '0;
            n_pcnt = '0;
        end

        if (out_ch == CH_LF) begin
            n_pos = '0;
        end

        // "the" detector, saturating count
        hit = ((n_prev1 == CH_T_LO) || (n_prev1 == CH_T_UP)) &&
              ((n_prev0 == CH_H_LO) || (n_prev0 == CH_H_UP)) &&
              ((out_ch == CH_E_LO) || (out_ch == CH_E_UP));
        if (hit && n_cnt != COUNT_MAX) begin
            n_cnt = n_cnt + 1'b1;
        end
        n_prev1 = n_prev0;
        n_prev0 = out_ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_pos       <= '0;
            r_pend      <= '0;
            r_pcnt      <= '0;
            r_prev0     <= CH_ZERO;
            r_prev1     <= CH_ZERO;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_key       <= n_key;
                r_pos       <= n_pos;
                r_pend      <= n_pend;
                r_pcnt      <= n_pcnt;
                r_prev0     <= n_prev0;
                r_prev1     <= n_prev1;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_char  <= out_ch;
            r_out_count <= n_cnt;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_char    = r_out_char;
    assign o_out.match_count = r_out_count;

`ifndef SYNTHESIS
    a_pcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= PCNT_OVER)
        else $error("digit run counter out of range");

    a_space_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop && i_q_item.is_space |=> r_out_char == $past(i_q_item.ch))
        else $error("tab, LF or CR was altered");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop && !i_q_item.start && r_cnt == COUNT_MAX |=> r_cnt == COUNT_MAX)
        else $error("match count wrapped");
`endif

endmodule

### hw/rtl/rekeying_printable_shift_cipher.sv
`timescale 1ns / 1ps

// Rekeying printable shift cipher.
// i_in carries one 7-bit character per request plus a start-of-text flag that
// reloads key, digit position, digit run, history and match count first.
// o_out returns exactly one result per request: the shifted character (tab, LF
// and CR unchanged) and the saturating count of "the" seen so far.
// i_cfg writes register 0 (direction: 0 encode, 1 decode) and register 1
// (start key, used at the next start of text); it is always ready.
// A start-key write is split into decimal digits one per cycle while no further
// i_cfg write arrives, so i_in is held off until every key digit is done.
// A result passes the input stage, 2-entry queue and state/output stage after
// its request is accepted. One character per cycle while o_out is ready and no
// key conversion runs, limited by the key and digit-run update in the back end.
// When o_out stalls, the output register holds and the queue and input stage
// keep taking up to three further requests before i_in.ready drops.
// Reset (synchronous, active low) clears the configuration to encode with
// key 0 and clears all text state and the pipeline.
module rekeying_printable_shift_cipher import rpsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpsc_in_if.sink    i_in,
    rpsc_out_if.source o_out,
    rpsc_cfg_if.sink   i_cfg
);

    t_cfg  cfg;
    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_item f_item;
    t_item q_item;

    rpsc_keyconv u_keyconv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    rpsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_busy  (cfg.busy),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item)
    );

    rpsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (full),
        .o_item  (q_item)
    );

    rpsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .i_cfg     (cfg),
        .o_q_pop   (pop),
        .o_out     (o_out)
    );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rpsc_pkg::*;

    localparam int CYCLE_LIMIT    = 100_000;
    localparam int PHASE_ITEMS    = 140;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              sot;
    } t_text_item;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] count;
    } t_cipher_out;

    // Tracks the cipher state and the results still owed by the block
    class shift_cipher_checker;
        logic               direction;
        logic [KEY_W-1:0]   start_key;
        logic [DIGIT_W-1:0] key_digit [KEY_DIGITS];
        int unsigned        key_pos;
        logic [DIGIT_W-1:0] run_digit [KEY_DIGITS];
        int unsigned        run_len;
        logic [CHAR_W-1:0]  last_char;
        logic [CHAR_W-1:0]  prior_char;
        logic [COUNT_W-1:0] the_total;
        t_cipher_out        expected_out [$];
        int unsigned        errors;

        function new();
            direction = 1'b0;
            start_key = '0;
            errors    = 0;
            restart_text();
        endfunction

        // Start of text: key from the start key register, history '0','0'
        function void restart_text();
            int unsigned v;
            int i;
            v = start_key;
            for (i = KEY_DIGITS - 1; i >= 0; i--) begin
                key_digit[i] = DIGIT_W'(v % 10);
                v = v / 10;
            end
            key_pos = 0;
            drop_run();
            last_char  = CH_ZERO;
            prior_char = CH_ZERO;
            the_total  = '0;
        endfunction

        function bit is_blank(int unsigned c);
            return c == CH_TAB || c == CH_LF || c == CH_CR;
        endfunction

        // A zero only extends a run that already started
        function bit is_run_digit(int unsigned c);
            return (c >= CH_ONE && c <= CH_NINE) || (c == CH_ZERO && run_len != 0);
        endfunction

        function int unsigned shift_char(int unsigned c);
            int unsigned d;
            d       = key_digit[key_pos];
            key_pos = (key_pos + 1) % KEY_DIGITS;
            if (!direction) begin
                if (c + d > CH_HI8) c = c % WRAP8;
                c = c + d;
            end else begin
                if (c < CH_LO8 + d) c = c + WRAP8;
                c = c - d;
            end
            return c % (1 << CHAR_W);
        endfunction

        function void push_digit(int unsigned c);
            int i;
            if (run_len < KEY_DIGITS) begin
                for (i = 0; i < KEY_DIGITS - 1; i++) run_digit[i] = run_digit[i + 1];
                run_digit[KEY_DIGITS - 1] = DIGIT_W'(c - CH_ZERO);
                run_len++;
            end else begin
                run_len = KEY_DIGITS + 1;
            end
        endfunction

        function void drop_run();
            int i;
            for (i = 0; i < KEY_DIGITS; i++) run_digit[i] = '0;
            run_len = 0;
        endfunction

        function void take_run();
            key_digit = run_digit;
            drop_run();
            key_pos = 0;
        endfunction

        // One character through the cipher; returns the output and match count
        function t_cipher_out cipher_step(logic [CHAR_W-1:0] ch, logic sot);
            int unsigned c;
            t_cipher_out res;
            c = ch;
            if (sot) restart_text();
            if (!direction) begin
                // plaintext is the input
                if (is_run_digit(c)) begin
                    push_digit(c);
                    c = shift_char(c);
                end else if (run_len != 0 && run_len <= KEY_DIGITS) begin
                    if (!is_blank(c)) c = shift_char(c);
                    take_run();
                end else begin
                    if (run_len != 0) drop_run();
                    if (!is_blank(c)) c = shift_char(c);
                end
            end else begin
                // plaintext is the output
                if (!is_blank(c)) c = shift_char(c);
                else if (c == CH_LF) key_pos = 0;
                if (is_run_digit(c)) push_digit(c);
                else if (run_len != 0 && run_len <= KEY_DIGITS) take_run();
                else if (run_len != 0) drop_run();
            end
            if (c == CH_LF) key_pos = 0;

            if ((prior_char == CH_T_LO || prior_char == CH_T_UP) &&
                (last_char == CH_H_LO || last_char == CH_H_UP) &&
                (c == CH_E_LO || c == CH_E_UP) && the_total != COUNT_MAX)
                the_total++;
            prior_char = last_char;
            last_char  = CHAR_W'(c);

            res.ch    = CHAR_W'(c);
            res.count = the_total;
            return res;
        endfunction

        function void write_register(t_cfg_idx idx, logic [KEY_W-1:0] value);
            case (idx)
                CFG_DIRECTION: direction = value[0];
                CFG_START_KEY: start_key = value;
                default: ;
            endcase
        endfunction

        function void note_request(logic [CHAR_W-1:0] ch, logic sot);
            expected_out.push_back(cipher_step(ch, sot));
        endfunction

        function void check_result(logic [CHAR_W-1:0] ch, logic [COUNT_W-1:0] count);
            t_cipher_out want;
            if (expected_out.size() == 0) begin
                $error("out_char: expected no result, got %0d", ch);
                errors++;
                return;
            end
            want = expected_out.pop_front();
            if (want.ch !== ch) begin
                $error("out_char: expected %0d, got %0d", want.ch, ch);
                errors++;
            end
            if (want.count !== count) begin
                $error("match_count: expected %0d, got %0d", want.count, count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rpsc_in_if  in_ch ();
    rpsc_out_if out_ch ();
    rpsc_cfg_if cfg_ch ();

    rekeying_printable_shift_cipher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    shift_cipher_checker cipher_check = new();
    shift_cipher_checker text_encoder = new();

    t_text_item  text_q [$];
    logic        phase_dir;
    bit          open_text;
    int          send_idle_pct;
    int          stall_pct;
    int unsigned cycle_count = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter for the timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    // Result side backpressure
    always @(posedge i_clk) begin
        out_ch.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end

    // Watch all three channels for accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                cipher_check.write_register(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                cipher_check.note_request(in_ch.in_char, in_ch.start_of_text);
            if (out_ch.valid && out_ch.ready)
                cipher_check.check_result(out_ch.out_char, out_ch.match_count);
        end
    end

    function automatic void push_raw(logic [CHAR_W-1:0] ch, logic sot);
        t_text_item item;
        item.ch  = ch;
        item.sot = sot;
        text_q.push_back(item);
    endfunction

    // Plaintext character; encrypted first when the block decodes
    function automatic void push_plain(logic [CHAR_W-1:0] ch);
        t_cipher_out enc;
        logic sot;
        sot       = open_text;
        open_text = 1'b0;
        if (phase_dir) begin
            enc = text_encoder.cipher_step(ch, sot);
            ch  = enc.ch;
        end
        push_raw(ch, sot);
    endfunction

    function automatic void push_string(string s);
        int i;
        for (i = 0; i < s.len(); i++) push_plain(CHAR_W'(s[i]));
    endfunction

    function automatic void push_digit_run(int len);
        push_plain(CHAR_W'(CH_ZERO + $urandom_range(1, 9)));
        repeat (len - 1) push_plain(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    // Mostly well-formed texts with words, key runs and line breaks; some noise
    function automatic void add_sequence();
        int pieces;
        if ($urandom_range(99) < 80) begin
            pieces    = $urandom_range(3, 10);
            open_text = 1'b1;
            repeat (pieces) begin
                case ($urandom_range(11))
                    0, 1, 2: begin
                        push_plain($urandom_range(1) ? CH_T_UP : CH_T_LO);
                        push_plain($urandom_range(1) ? CH_H_UP : CH_H_LO);
                        push_plain($urandom_range(1) ? CH_E_UP : CH_E_LO);
                    end
                    3: push_digit_run($urandom_range(1, KEY_DIGITS));
                    4: push_digit_run($urandom_range(KEY_DIGITS + 1, KEY_DIGITS + 3));
                    5: push_plain(CH_LF);
                    6: push_plain($urandom_range(1) ? CH_TAB : CH_CR);
                    7: push_plain(CHAR_W'(CH_LO8));
                    default: begin
                        repeat ($urandom_range(1, 3))
                            push_plain(CHAR_W'($urandom_range(CH_LO8, CH_HI8)));
                    end
                endcase
            end
        end else begin
            repeat ($urandom_range(3, 12))
                push_raw(CHAR_W'($urandom_range(0, (1 << CHAR_W) - 1)),
                         $urandom_range(7) == 0);
        end
    endfunction

    task automatic wait_drained();
        while (cipher_check.expected_out.size() != 0) @(posedge i_clk);
    endtask

    // Both registers, back to back on the config channel
    task automatic write_config(logic dir, logic [KEY_W-1:0] key);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_DIRECTION;
        cfg_ch.data  <= KEY_W'(dir);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.index <= CFG_START_KEY;
        cfg_ch.data  <= key;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_text();
        t_text_item item;
        while (text_q.size() != 0) begin
            item = text_q.pop_front();
            while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            in_ch.valid         <= 1'b1;
            in_ch.in_char       <= item.ch;
            in_ch.start_of_text <= item.sot;
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
        end
        in_ch.valid <= 1'b0;
    endtask

    // Settings change only once every result is back
    task automatic start_phase(logic dir, int unsigned key, int send_pct, int stall);
        wait_drained();
        send_idle_pct = send_pct;
        stall_pct     = stall;
        write_config(dir, KEY_W'(key));
        phase_dir              = dir;
        text_encoder.start_key = KEY_W'(key);
    endtask

    task automatic random_phase(logic dir, int unsigned key, int send_pct, int stall);
        start_phase(dir, key, send_pct, stall);
        while (text_q.size() < PHASE_ITEMS) add_sequence();
        send_text();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        send_idle_pct       = 0;
        stall_pct           = 0;
        phase_dir           = 1'b0;
        open_text           = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.in_char       = '0;
        in_ch.start_of_text = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_DIRECTION;
        cfg_ch.data         = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: key 9999 encode; wraps, blanks, DEL, output LF, "the" in both
        // cases, leading zero, rekey, over-long run, run closed by CR, restart
        start_phase(1'b0, 9999, 0, 0);
        open_text = 1'b1;
        push_plain(CHAR_W'(0));
        push_plain(CHAR_W'(1));
        push_plain(CHAR_W'(127));
        push_plain(CHAR_W'(CH_HI8));
        push_plain(CH_TAB);
        push_plain(CH_LF);
        push_string("k_\\K?<0705xa12345");
        push_plain(CH_TAB);
        push_string("9");
        push_plain(CH_CR);
        open_text = 1'b1;
        push_plain(CH_T_LO);
        send_text();

        random_phase(1'b0, 5038,  0,  0);
        random_phase(1'b1, 9999,  77, 0);
        random_phase(1'b0, 16383, 0,  77);
        random_phase(1'b1, 0,     8,  8);
        random_phase(1'b1, 271,   0,  0);
        random_phase(1'b0, 9,     77, 0);
        random_phase(1'b1, 10000, 0,  77);
        random_phase(1'b0, 1200,  8,  8);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (cipher_check.errors == 0 && cipher_check.expected_out.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
